// ----- hdl/fcce_pkg.sv -----
package fcce_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CL_W    = 16;
  localparam int OFF_W   = 32;
  localparam int SECT_W  = 32;
  localparam int OIS_W   = 9;
  localparam int DSS_W   = 24;
  localparam int SPC_W   = 8;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 1;

  // 512-byte sectors
  localparam int SECT_SHIFT = 9;
  localparam int JUMP_W     = OFF_W - SECT_SHIFT;
  localparam int DEN_W      = (CNT_W > SPC_W) ? CNT_W : SPC_W;
  localparam int DIV_CNT_W  = $clog2(JUMP_W + 1);
  localparam int PROD_W     = ADDR_W + SPC_W;

  localparam logic [CL_W-1:0] LINK_FREE     = 16'h0000;
  localparam logic [CL_W-1:0] LINK_LAST_MIN = 16'hFFF8;
  localparam logic [CL_W-1:0] LINK_END      = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_LOCATE = 2'd2,
    CMD_ALLOC  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } stat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DSS = 1'b0,
    CFG_SPC = 1'b1
  } cfg_idx_e;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_WR_ENTRY,
    OP_RD_ENTRY,
    OP_DIV_JUMPS,
    OP_WALK_INIT1,
    OP_HOP_RD,
    OP_HOP_UPD,
    OP_LEN_INIT,
    OP_LEN_RD,
    OP_LEN_UPD,
    OP_DIV_REST,
    OP_WALK_INIT2,
    OP_SECT,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_MARK,
    OP_LINK,
    OP_RESULT
  } dp_op_e;

  // kind of result word loaded by OP_RESULT
  typedef enum logic [2:0] {
    RES_OK0,
    RES_RD,
    RES_RANGE,
    RES_END,
    RES_FULL,
    RES_LOC,
    RES_ALLOC
  } res_e;

  typedef struct packed {
    dp_op_e op;
    res_e   res;
    logic   in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    cmd_e cmd;
    logic cl_oor;
    logic cl_nz;
    logic hops_zero;
    logic cur_end;
    logic cur_oor;
    logic cur_one;
    logic rest_nz;
    logic div_busy;
    logic probe_hit;
    logic scan_hit;
    logic scan_last;
    logic clr_last;
  } dp_stat_t;

endpackage

// ----- hdl/fcce_if.sv -----
interface fcce_in_if;
  import fcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CL_W-1:0]   cluster;
  logic [CL_W-1:0]   value;
  logic [OFF_W-1:0]  byte_offset;

  modport source (output valid, output command, output cluster, output value,
                  output byte_offset, input ready);
  modport sink (input valid, input command, input cluster, input value,
                input byte_offset, output ready);
endinterface

interface fcce_out_if;
  import fcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CL_W-1:0]   found_cluster;
  logic [SECT_W-1:0] sector;
  logic [OIS_W-1:0]  byte_in_sector;

  modport source (output valid, output status, output found_cluster, output sector,
                  output byte_in_sector, input ready);
  modport sink (input valid, input status, input found_cluster, input sector,
                input byte_in_sector, output ready);
endinterface

// ----- hdl/fcce_ram.sv -----
module fcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/fcce_div.sv -----
module fcce_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fcce_pkg::JUMP_W-1:0] num_i,
  input  logic [fcce_pkg::DEN_W-1:0]  den_i,
  output logic                        busy_o,
  output logic [fcce_pkg::JUMP_W-1:0] quo_o,
  output logic [fcce_pkg::DEN_W-1:0]  rem_o
);
  import fcce_pkg::*;

  logic [JUMP_W-1:0]    quo_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[JUMP_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(JUMP_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[JUMP_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/fcce_datapath.sv -----
module fcce_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  fcce_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [fcce_pkg::CFG_W-1:0] cfg_data_i,
  fcce_in_if.sink                    in_i,
  fcce_out_if.source                 out_o,
  input  fcce_pkg::dp_cmd_t          cmd_i,
  output fcce_pkg::dp_stat_t         stat_o
);
  import fcce_pkg::*;

  // configuration
  logic [DSS_W-1:0] dss_q;
  logic [SPC_W-1:0] spc_q;
  logic [SPC_W-1:0] spc_eff;

  // latched input word
  cmd_e             cmd_q;
  logic [CL_W-1:0]  cl_q;
  logic [CL_W-1:0]  val_q;
  logic [OFF_W-1:0] off_q;

  // walk state
  logic [CL_W-1:0]   cur_q;
  logic [CNT_W-1:0]  hops_q;
  logic [JUMP_W-1:0] jumps_q;
  logic [SPC_W-1:0]  rsect_q;
  logic [CL_W-1:0]   probe_q;
  logic [CNT_W-1:0]  len_q;
  logic [SECT_W-1:0] sector_q;
  logic [JUMP_W-1:0] rest;
  logic [PROD_W-1:0] prod;

  // scan and clear
  logic [ADDR_W-1:0] scan_q;
  logic [ADDR_W-1:0] pend_q;
  logic              pend_vld_q;
  logic [ADDR_W-1:0] found_q;
  logic [ADDR_W-1:0] clr_q;

  // result register
  logic              out_vld_q;
  stat_e             res_stat_q;
  logic [CL_W-1:0]   res_found_q;
  logic [SECT_W-1:0] res_sector_q;
  logic [OIS_W-1:0]  res_ois_q;

  // memory and divider
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CL_W-1:0]   mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CL_W-1:0]   rd_data;

  logic              div_start;
  logic [JUMP_W-1:0] div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_busy;
  logic [JUMP_W-1:0] div_quo;
  logic [DEN_W-1:0]  div_rem;

  assign spc_eff = (spc_q == '0) ? SPC_W'(1) : spc_q;
  assign rest    = jumps_q - JUMP_W'(TABLE_ENTRIES);
  assign prod    = PROD_W'(cur_q[ADDR_W-1:0] - ADDR_W'(2)) * PROD_W'(spc_eff);

  assign div_start = (cmd_i.op == OP_DIV_JUMPS) || (cmd_i.op == OP_DIV_REST);
  assign div_num   = (cmd_i.op == OP_DIV_REST) ? rest : off_q[OFF_W-1:SECT_SHIFT];
  assign div_den   = (cmd_i.op == OP_DIV_REST) ? DEN_W'(len_q) : DEN_W'(spc_eff);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = LINK_FREE;
    mem_re    = 1'b0;
    mem_raddr = cur_q[ADDR_W-1:0];
    case (cmd_i.op)
      OP_CLR: begin
        mem_we = 1'b1;
      end
      OP_WR_ENTRY: begin
        mem_we    = 1'b1;
        mem_waddr = cl_q[ADDR_W-1:0];
        mem_wdata = val_q;
      end
      OP_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = pend_q;
        mem_wdata = LINK_END;
      end
      OP_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = cl_q[ADDR_W-1:0];
        mem_wdata = CL_W'(found_q);
      end
      OP_RD_ENTRY: begin
        mem_re    = 1'b1;
        mem_raddr = cl_q[ADDR_W-1:0];
      end
      OP_HOP_RD: begin
        mem_re = 1'b1;
      end
      OP_LEN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = probe_q[ADDR_W-1:0];
      end
      OP_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_q;
      end
      default: begin
      end
    endcase
  end

  fcce_ram #(
    .WIDTH (CL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  fcce_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dss_q      <= '0;
      spc_q      <= SPC_W'(1);
      clr_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DSS: dss_q <= cfg_data_i[DSS_W-1:0];
          CFG_SPC: spc_q <= cfg_data_i[SPC_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_CLR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.op == OP_SCAN_INIT) begin
        pend_vld_q <= 1'b0;
      end else if (cmd_i.op == OP_SCAN) begin
        pend_vld_q <= 1'b1;
      end
      if (cmd_i.op == OP_RESULT) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q <= cmd_e'(in_i.command);
        cl_q  <= in_i.cluster;
        val_q <= in_i.value;
        off_q <= in_i.byte_offset;
      end
      OP_WALK_INIT1: begin
        jumps_q <= div_quo;
        rsect_q <= div_rem[SPC_W-1:0];
        hops_q  <= (div_quo > JUMP_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                       : div_quo[CNT_W-1:0];
        cur_q   <= cl_q;
      end
      OP_HOP_RD: hops_q <= hops_q - CNT_W'(1);
      OP_HOP_UPD: cur_q <= rd_data;
      OP_LEN_INIT: begin
        probe_q <= cur_q;
        len_q   <= '0;
      end
      OP_LEN_UPD: begin
        probe_q <= rd_data;
        len_q   <= len_q + CNT_W'(1);
      end
      OP_WALK_INIT2: hops_q <= div_rem[CNT_W-1:0];
      OP_SECT: sector_q <= SECT_W'(dss_q) + SECT_W'(prod) + SECT_W'(rsect_q);
      OP_SCAN_INIT: scan_q <= ADDR_W'(2);
      OP_SCAN: begin
        scan_q <= scan_q + ADDR_W'(1);
        pend_q <= scan_q;
      end
      OP_MARK: found_q <= pend_q;
      OP_RESULT: begin
        res_stat_q   <= ST_OK;
        res_found_q  <= '0;
        res_sector_q <= '0;
        res_ois_q    <= '0;
        case (cmd_i.res)
          RES_OK0: begin
          end
          RES_RD: res_found_q <= rd_data;
          RES_RANGE: res_stat_q <= ST_RANGE;
          RES_END: res_stat_q <= ST_END;
          RES_FULL: res_stat_q <= ST_FULL;
          RES_LOC: begin
            res_found_q  <= cur_q;
            res_sector_q <= sector_q;
            res_ois_q    <= off_q[OIS_W-1:0];
          end
          RES_ALLOC: res_found_q <= CL_W'(found_q);
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready           = cmd_i.in_ready;
  assign out_o.valid          = out_vld_q;
  assign out_o.status         = res_stat_q;
  assign out_o.found_cluster  = res_found_q;
  assign out_o.sector         = res_sector_q;
  assign out_o.byte_in_sector = res_ois_q;

  always_comb begin
    stat_o.in_valid  = in_i.valid;
    stat_o.out_free  = !out_vld_q || out_o.ready;
    stat_o.cmd       = cmd_q;
    stat_o.cl_oor    = cl_q >= CL_W'(TABLE_ENTRIES);
    stat_o.cl_nz     = cl_q != LINK_FREE;
    stat_o.hops_zero = hops_q == '0;
    stat_o.cur_end   = (cur_q == LINK_FREE) || (cur_q >= LINK_LAST_MIN);
    stat_o.cur_oor   = cur_q >= CL_W'(TABLE_ENTRIES);
    stat_o.cur_one   = cur_q == CL_W'(1);
    stat_o.rest_nz   = jumps_q > JUMP_W'(TABLE_ENTRIES);
    stat_o.div_busy  = div_busy;
    stat_o.probe_hit = rd_data == cur_q;
    stat_o.scan_hit  = pend_vld_q && (rd_data == LINK_FREE);
    stat_o.scan_last = pend_vld_q && (pend_q == ADDR_W'(TABLE_ENTRIES - 1));
    stat_o.clr_last  = clr_q == ADDR_W'(TABLE_ENTRIES - 1);
  end

endmodule

// ----- hdl/fcce_ctrl.sv -----
module fcce_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcce_pkg::dp_stat_t stat_i,
  output fcce_pkg::dp_cmd_t  cmd_o
);
  import fcce_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR     = 14'h0001,
    S_IDLE      = 14'h0002,
    S_DISPATCH  = 14'h0004,
    S_DIV1      = 14'h0008,
    S_WALK_TEST = 14'h0010,
    S_WALK_WAIT = 14'h0020,
    S_LEN_RD    = 14'h0040,
    S_LEN_WAIT  = 14'h0080,
    S_DIV2_GO   = 14'h0100,
    S_DIV2      = 14'h0200,
    S_FINAL     = 14'h0400,
    S_SCAN      = 14'h0800,
    S_LINK      = 14'h1000,
    S_DONE      = 14'h2000
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;
  logic   phase_q, phase_d;

  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    phase_d        = phase_q;
    cmd_o.op       = OP_NONE;
    cmd_o.res      = res_q;
    cmd_o.in_ready = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_WRITE: begin
            state_d = S_DONE;
            if (stat_i.cl_oor) begin
              res_d = RES_RANGE;
            end else begin
              cmd_o.op = OP_WR_ENTRY;
              res_d    = RES_OK0;
            end
          end
          CMD_READ: begin
            state_d = S_DONE;
            if (stat_i.cl_oor) begin
              res_d = RES_RANGE;
            end else begin
              cmd_o.op = OP_RD_ENTRY;
              res_d    = RES_RD;
            end
          end
          CMD_LOCATE: begin
            cmd_o.op = OP_DIV_JUMPS;
            phase_d  = 1'b0;
            state_d  = S_DIV1;
          end
          CMD_ALLOC: begin
            if (stat_i.cl_oor) begin
              res_d   = RES_RANGE;
              state_d = S_DONE;
            end else begin
              cmd_o.op = OP_SCAN_INIT;
              state_d  = S_SCAN;
            end
          end
          default: begin
            res_d   = RES_RANGE;
            state_d = S_DONE;
          end
        endcase
      end
      S_DIV1: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_WALK_INIT1;
          state_d  = S_WALK_TEST;
        end
      end
      S_WALK_TEST: begin
        if (stat_i.hops_zero) begin
          // a long offset has the walk go round a loop: measure it first
          if (!phase_q && stat_i.rest_nz) begin
            cmd_o.op = OP_LEN_INIT;
            state_d  = S_LEN_RD;
          end else begin
            state_d = S_FINAL;
          end
        end else if (stat_i.cur_end) begin
          res_d   = RES_END;
          state_d = S_DONE;
        end else if (stat_i.cur_oor) begin
          res_d   = RES_RANGE;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_HOP_RD;
          state_d  = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        cmd_o.op = OP_HOP_UPD;
        state_d  = S_WALK_TEST;
      end
      S_LEN_RD: begin
        cmd_o.op = OP_LEN_RD;
        state_d  = S_LEN_WAIT;
      end
      S_LEN_WAIT: begin
        cmd_o.op = OP_LEN_UPD;
        state_d  = stat_i.probe_hit ? S_DIV2_GO : S_LEN_RD;
      end
      S_DIV2_GO: begin
        cmd_o.op = OP_DIV_REST;
        state_d  = S_DIV2;
      end
      S_DIV2: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_WALK_INIT2;
          phase_d  = 1'b1;
          state_d  = S_WALK_TEST;
        end
      end
      S_FINAL: begin
        state_d = S_DONE;
        if (stat_i.cur_end) begin
          res_d = RES_END;
        end else if (stat_i.cur_oor || stat_i.cur_one) begin
          res_d = RES_RANGE;
        end else begin
          cmd_o.op = OP_SECT;
          res_d    = RES_LOC;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          cmd_o.op = OP_MARK;
          if (stat_i.cl_nz) begin
            state_d = S_LINK;
          end else begin
            res_d   = RES_ALLOC;
            state_d = S_DONE;
          end
        end else if (stat_i.scan_last) begin
          res_d   = RES_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_SCAN;
        end
      end
      S_LINK: begin
        cmd_o.op = OP_LINK;
        res_d    = RES_ALLOC;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= RES_OK0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- hdl/fat16_cluster_chain_engine_unit.sv -----
// FAT16 cluster chain engine: keeps a 4096-entry allocation table in an internal RAM
// and answers write, read, locate and allocate commands with one result word each.
// After reset the table is cleared one entry a cycle, during which no input word is
// taken; configuration writes are taken at any time the block is idle.
// One word is worked at a time. Locate runs the divider for the link count, then
// follows the links through the table RAM (up to 4096 links); an offset past 4096
// links has it also measure the loop it lands on, divide again and walk up to one
// more loop of links. Allocate reads one table entry a cycle from cluster 2 until a
// free one is found or the last entry is read. A finished result waits in an output
// register.
module fat16_cluster_chain_engine_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fcce_pkg::CFG_W-1:0]     cfg_data_i,
  fcce_in_if.sink                        in_i,
  fcce_out_if.source                     out_o
);
  import fcce_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  fcce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  fcce_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat)
  );

endmodule
